// ===== sv/dlle_pkg.sv =====
// dlle_pkg: shared types, codes and limits of the doubly linked list engine.
// Depends on nothing; every other file of the engine refers to it by scoped names.
package dlle_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int RESULT_LIMIT     = 32;

   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 6;

   localparam logic [OPCODE_W-1:0] OP_ADD_TAIL = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD_HEAD = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DELETE   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_OUT = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   typedef logic signed [VALUE_W-1:0] value_type;

   // one result as it leaves the controller
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      value_type           out_value;
      logic [POS_W-1:0]    position;
      logic                last;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_payload_type;

   // memory port controls from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_value;
      logic wr_next;
      logic wr_prev;
   } mem_ctl_type;

endpackage

// ===== sv/dlle_if.sv =====
// dlle_req_if / dlle_rsp_if: valid/ready channels of the list engine.
// Depends on dlle_pkg for payload types.
interface dlle_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [dlle_pkg::OPCODE_W-1:0]        opcode;
   dlle_pkg::value_type                  item_value;

   modport source (output valid, output opcode, output item_value, input ready);
   modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface dlle_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [dlle_pkg::STATUS_W-1:0]        status;
   dlle_pkg::value_type                  out_value;
   logic [dlle_pkg::POS_W-1:0]           position;
   logic                                 last;
   logic [dlle_pkg::COUNT_W-1:0]         entry_count;

   modport source (output valid, output status, output out_value, output position,
                   output last, output entry_count, input ready);
   modport sink   (input valid, input status, input out_value, input position,
                   input last, input entry_count, output ready);
endinterface

// ===== sv/dlle_mem.sv =====
// dlle_mem: slot memory (value, next link, previous link), one read, one write port.
// Depends on dlle_pkg; read data is registered.
module dlle_mem #(
   parameter int  CAPACITY = dlle_pkg::CAPACITY_DEFAULT,
   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int IW = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  dlle_pkg::mem_ctl_type ctl,
   input  logic [SW-1:0]         rd_addr,
   input  logic [SW-1:0]         wr_addr,
   input  dlle_pkg::value_type   wr_value_data,
   input  logic [IW-1:0]         wr_next_data,
   input  logic [IW-1:0]         wr_prev_data,
   output dlle_pkg::value_type   rd_value,
   output logic [IW-1:0]         rd_next,
   output logic [IW-1:0]         rd_prev
);

   dlle_pkg::value_type value_mem [CAPACITY];
   logic [IW-1:0]       next_mem  [CAPACITY];
   logic [IW-1:0]       prev_mem  [CAPACITY];

   dlle_pkg::value_type rd_value_ff;
   logic [IW-1:0]       rd_next_ff;
   logic [IW-1:0]       rd_prev_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_value) begin
         value_mem[wr_addr] <= wr_value_data;
      end
      if (ctl.wr_next) begin
         next_mem[wr_addr] <= wr_next_data;
      end
      if (ctl.wr_prev) begin
         prev_mem[wr_addr] <= wr_prev_data;
      end
   end

   // read data holds while no read is issued (output stall)
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_value_ff <= value_mem[rd_addr];
         rd_next_ff  <= next_mem[rd_addr];
         rd_prev_ff  <= prev_mem[rd_addr];
      end
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_next_ff;
   assign rd_prev  = rd_prev_ff;

endmodule

// ===== sv/dlle_ctrl.sv =====
// dlle_ctrl: list sequencer - head/tail/count, slot usage, link updates and walks.
// Depends on dlle_pkg; drives dlle_mem and hands results to the output register.
module dlle_ctrl #(
   parameter int  CAPACITY = dlle_pkg::CAPACITY_DEFAULT,
   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int IW = $clog2(CAPACITY + 1),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dlle_pkg::OPCODE_W-1:0] req_opcode,
   input  dlle_pkg::value_type           req_value,
   input  logic                          can_load,
   output logic                          emit,
   output dlle_pkg::rsp_payload_type     emit_payload,
   output dlle_pkg::mem_ctl_type         mem_ctl,
   output logic [SW-1:0]                 mem_rd_addr,
   output logic [SW-1:0]                 mem_wr_addr,
   output dlle_pkg::value_type           mem_wr_value,
   output logic [IW-1:0]                 mem_wr_next,
   output logic [IW-1:0]                 mem_wr_prev,
   input  dlle_pkg::value_type           mem_rd_value,
   input  logic [IW-1:0]                 mem_rd_next,
   input  logic [IW-1:0]                 mem_rd_prev
);

   localparam logic [IW-1:0] LINK_NONE = IW'(CAPACITY);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_ADD_LINK = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_FIX_NEXT = 3'd3;
   localparam logic [2:0] S_FIX_PREV = 3'd4;
   localparam logic [2:0] S_READ     = 3'd5;
   localparam logic [2:0] S_RESP     = 3'd6;

   logic [2:0]                    state_ff, state_in;
   logic [dlle_pkg::OPCODE_W-1:0] op_ff, op_in;
   dlle_pkg::value_type           val_ff, val_in;
   logic [dlle_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [IW-1:0]                 head_ff, head_in;
   logic [IW-1:0]                 tail_ff, tail_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CAPACITY-1:0]           used_ff, used_in;
   logic [IW-1:0]                 slot_ff, slot_in;
   logic [IW-1:0]                 cur_ff, cur_in;
   logic [IW-1:0]                 plink_ff, plink_in;
   logic [IW-1:0]                 nlink_ff, nlink_in;
   logic [5:0]                    k_ff, k_in;

   logic          free_found;
   logic [SW-1:0] free_slot;
   logic          list_empty;
   logic          rd_fin;

   function automatic logic link_ok(input logic [IW-1:0] idx);
      link_ok = (idx < LINK_NONE);
   endfunction

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SW'(i);
         end
      end
   end

   assign list_empty = !link_ok(head_ff);
   assign rd_fin     = !link_ok(mem_rd_next)
                       || (k_ff == 6'(dlle_pkg::RESULT_LIMIT - 1))
                       || (k_ff == 6'(CAPACITY - 1));
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      status_in = status_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      used_in   = used_ff;
      slot_in   = slot_ff;
      cur_in    = cur_ff;
      plink_in  = plink_ff;
      nlink_in  = nlink_ff;
      k_in      = k_ff;

      mem_ctl      = '0;
      mem_rd_addr  = '0;
      mem_wr_addr  = '0;
      mem_wr_value = val_ff;
      mem_wr_next  = LINK_NONE;
      mem_wr_prev  = LINK_NONE;

      emit         = 1'b0;
      emit_payload = '{status: status_ff, out_value: val_ff, position: '0,
                       last: 1'b1, entry_count: dlle_pkg::COUNT_W'(count_ff)};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_opcode;
               val_in = req_value;
               case (req_opcode)
                  dlle_pkg::OP_ADD_TAIL, dlle_pkg::OP_ADD_HEAD: begin
                     if (!free_found) begin
                        status_in = dlle_pkg::ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        mem_ctl.wr_value = 1'b1;
                        mem_ctl.wr_next  = 1'b1;
                        mem_ctl.wr_prev  = 1'b1;
                        mem_wr_addr      = free_slot;
                        mem_wr_value     = req_value;
                        if (!list_empty && req_opcode == dlle_pkg::OP_ADD_HEAD) begin
                           mem_wr_next = head_ff;
                        end
                        if (!list_empty && req_opcode == dlle_pkg::OP_ADD_TAIL) begin
                           mem_wr_prev = tail_ff;
                        end
                        used_in[free_slot] = 1'b1;
                        slot_in            = IW'(free_slot);
                        status_in          = dlle_pkg::ST_OK;
                        if (list_empty) begin
                           head_in  = IW'(free_slot);
                           tail_in  = IW'(free_slot);
                           count_in = count_ff + 1'b1;
                           state_in = S_RESP;
                        end else begin
                           state_in = S_ADD_LINK;
                        end
                     end
                  end
                  dlle_pkg::OP_DELETE: begin
                     if (list_empty) begin
                        status_in = dlle_pkg::ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = head_ff[SW-1:0];
                        cur_in        = head_ff;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                     if (list_empty) begin
                        status_in = dlle_pkg::ST_EMPTY;
                        val_in    = '0;
                        state_in  = S_RESP;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = head_ff[SW-1:0];
                        k_in          = '0;
                        state_in      = S_READ;
                     end
                  end
               endcase
            end
         end

         S_ADD_LINK: begin
            if (op_ff == dlle_pkg::OP_ADD_TAIL) begin
               mem_ctl.wr_next = 1'b1;
               mem_wr_addr     = tail_ff[SW-1:0];
               mem_wr_next     = slot_ff;
               tail_in         = slot_ff;
            end else begin
               mem_ctl.wr_prev = 1'b1;
               mem_wr_addr     = head_ff[SW-1:0];
               mem_wr_prev     = slot_ff;
               head_in         = slot_ff;
            end
            count_in = count_ff + 1'b1;
            state_in = S_RESP;
         end

         S_SCAN: begin
            if (mem_rd_value == val_ff) begin
               plink_in                 = mem_rd_prev;
               nlink_in                 = mem_rd_next;
               used_in[cur_ff[SW-1:0]]  = 1'b0;
               count_in                 = count_ff - 1'b1;
               state_in                 = S_FIX_NEXT;
            end else if (link_ok(mem_rd_next)) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = mem_rd_next[SW-1:0];
               cur_in        = mem_rd_next;
            end else begin
               status_in = dlle_pkg::ST_NOT_FOUND;
               state_in  = S_RESP;
            end
         end

         S_FIX_NEXT: begin
            if (link_ok(plink_ff)) begin
               mem_ctl.wr_next = 1'b1;
               mem_wr_addr     = plink_ff[SW-1:0];
               mem_wr_next     = nlink_ff;
            end else begin
               head_in = nlink_ff;
            end
            state_in = S_FIX_PREV;
         end

         S_FIX_PREV: begin
            if (link_ok(nlink_ff)) begin
               mem_ctl.wr_prev = 1'b1;
               mem_wr_addr     = nlink_ff[SW-1:0];
               mem_wr_prev     = plink_ff;
            end else begin
               tail_in = plink_ff;
            end
            status_in = dlle_pkg::ST_OK;
            state_in  = S_RESP;
         end

         S_READ: begin
            if (can_load) begin
               emit         = 1'b1;
               emit_payload = '{status: dlle_pkg::ST_OK, out_value: mem_rd_value,
                                position: dlle_pkg::POS_W'(k_ff), last: rd_fin,
                                entry_count: dlle_pkg::COUNT_W'(count_ff)};
               if (rd_fin) begin
                  state_in = S_IDLE;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  mem_rd_addr   = mem_rd_next[SW-1:0];
                  k_in          = k_ff + 1'b1;
               end
            end
         end

         S_RESP: begin
            if (can_load) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= LINK_NONE;
         tail_ff  <= LINK_NONE;
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      cur_ff    <= cur_in;
      plink_ff  <= plink_in;
      nlink_ff  <= nlink_in;
      k_ff      <= k_in;
   end

endmodule

// ===== sv/doubly_linked_list_engine_unit.sv =====
// Bounded doubly linked list engine: add at tail/head, delete first match, read out.
// Depends on dlle_pkg, dlle_if, dlle_mem and dlle_ctrl.
//
// Channels: req_ch takes one request (opcode, item_value); rsp_ch returns the results.
// Add and delete answer with one result; read out answers with one result per entry
// (at most 32), in list order, position counting from 0; the final result of every
// request carries last = 1. An empty read out gives one result with status empty.
// Slots, links and values live in dlle_mem (one read, one write port, registered read).
// One request is worked on at a time; req_ch.ready is high only while idle.
// Steps: an add writes the new slot; with a non-empty list it then patches the neighbor
// link in S_ADD_LINK. A delete reads entries from the head in S_SCAN until one matches,
// fixes the links in S_FIX_NEXT and S_FIX_PREV; one that finds no match stops at the tail.
// Each request then answers from S_RESP; a read out instead loads one entry per cycle from
// S_READ while the result register can take a new result.
// Results go through one output register; when the receiver holds rsp_ch.ready low,
// the walk simply pauses with the memory read data held, nothing is dropped.
// Reset (synchronous, active high) empties the list: head/tail to null, count zero,
// every slot free. Memory contents are not cleared, nor need they be.
module doubly_linked_list_engine_unit #(
   parameter int CAPACITY = dlle_pkg::CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dlle_req_if.sink   req_ch,
   dlle_rsp_if.source rsp_ch
);

   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IW = $clog2(CAPACITY + 1);

   dlle_pkg::mem_ctl_type     mem_ctl;
   logic [SW-1:0]             mem_rd_addr;
   logic [SW-1:0]             mem_wr_addr;
   dlle_pkg::value_type       mem_wr_value;
   logic [IW-1:0]             mem_wr_next;
   logic [IW-1:0]             mem_wr_prev;
   dlle_pkg::value_type       mem_rd_value;
   logic [IW-1:0]             mem_rd_next;
   logic [IW-1:0]             mem_rd_prev;

   logic                      emit;
   logic                      can_load;
   dlle_pkg::rsp_payload_type emit_payload;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   dlle_pkg::rsp_payload_type rsp_data_ff;

   // free to take a new result when empty or being drained this cycle
   assign can_load = !rsp_valid_ff || rsp_ch.ready;

   dlle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ch.ready),
      .req_opcode   (req_ch.opcode),
      .req_value    (req_ch.item_value),
      .can_load     (can_load),
      .emit         (emit),
      .emit_payload (emit_payload),
      .mem_ctl      (mem_ctl),
      .mem_rd_addr  (mem_rd_addr),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_value (mem_wr_value),
      .mem_wr_next  (mem_wr_next),
      .mem_wr_prev  (mem_wr_prev),
      .mem_rd_value (mem_rd_value),
      .mem_rd_next  (mem_rd_next),
      .mem_rd_prev  (mem_rd_prev)
   );

   dlle_mem #(.CAPACITY(CAPACITY)) u_mem (
      .clock         (clock),
      .ctl           (mem_ctl),
      .rd_addr       (mem_rd_addr),
      .wr_addr       (mem_wr_addr),
      .wr_value_data (mem_wr_value),
      .wr_next_data  (mem_wr_next),
      .wr_prev_data  (mem_wr_prev),
      .rd_value      (mem_rd_value),
      .rd_next       (mem_rd_next),
      .rd_prev       (mem_rd_prev)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= emit_payload;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_data_ff.status;
   assign rsp_ch.out_value   = rsp_data_ff.out_value;
   assign rsp_ch.position    = rsp_data_ff.position;
   assign rsp_ch.last        = rsp_data_ff.last;
   assign rsp_ch.entry_count = rsp_data_ff.entry_count;

endmodule

// ===== sv/dlle_checker.sv =====
// dlle_checker: port-level assertions for the list engine, bound to the top level.
// Depends on dlle_pkg and doubly_linked_list_engine_unit.
module dlle_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dlle_pkg::STATUS_W-1:0] rsp_status,
   input logic [dlle_pkg::POS_W-1:0]    rsp_position,
   input logic                          rsp_last
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // one request at a time: no new request the cycle after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // any failure status is a single, final result
   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != dlle_pkg::ST_OK) |-> rsp_last && (rsp_position == '0))
      else $error("failure result not final");

   // no request is taken while a result burst is still open
   a_busy_during_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken during read out");

endmodule

bind doubly_linked_list_engine_unit dlle_checker u_dlle_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_status   (rsp_ch.status),
   .rsp_position (rsp_ch.position),
   .rsp_last     (rsp_ch.last)
);
